// File: hdl/pde_pkg.sv
// Shared types, constants and microcode program for the polynomial derivative evaluator.
package pde_pkg;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Step addresses of the microcode program.
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_READ = 3'd1;
  localparam logic [2:0] STEP_MUL1 = 3'd2;
  localparam logic [2:0] STEP_MUL2 = 3'd3;
  localparam logic [2:0] STEP_ACC  = 3'd4;
  localparam logic [2:0] STEP_DONE = 3'd5;

  localparam int UCODE_DEPTH = 8;

  // Accumulator width: terms stay below 2^44, so 50 bits leave ample margin.
  localparam int ACC_W = 50;
  localparam logic signed [ACC_W-1:0] OUT_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -50'sh0_8000_0000_0000;

  localparam logic [15:0] TAU_ONE = 16'h8000;
  localparam int          FF_W    = 13;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_WAIT_IN,
    COND_EMPTY,
    COND_MORE,
    COND_WAIT_OUT
  } pde_cond_e;

  typedef struct packed {
    logic      init;
    logic      rd_coef;
    logic      mul1;
    logic      mul2;
    logic      acc;
    logic      out_load;
    pde_cond_e cond;
    logic [2:0] target;
  } pde_ctl_t;

  typedef struct packed {
    logic start;
    logic empty;
    logic more;
    logic out_busy;
  } pde_stat_t;

  // Falling factorial n(n-1)...(n-r+1), indexed [n][r].
  localparam logic [FF_W-1:0] FALL_TBL [8][8] = '{
    '{13'd1, 13'd0, 13'd0,  13'd0,   13'd0,   13'd0,    13'd0,    13'd0},
    '{13'd1, 13'd1, 13'd0,  13'd0,   13'd0,   13'd0,    13'd0,    13'd0},
    '{13'd1, 13'd2, 13'd2,  13'd0,   13'd0,   13'd0,    13'd0,    13'd0},
    '{13'd1, 13'd3, 13'd6,  13'd6,   13'd0,   13'd0,    13'd0,    13'd0},
    '{13'd1, 13'd4, 13'd12, 13'd24,  13'd24,  13'd0,    13'd0,    13'd0},
    '{13'd1, 13'd5, 13'd20, 13'd60,  13'd120, 13'd120,  13'd0,    13'd0},
    '{13'd1, 13'd6, 13'd30, 13'd120, 13'd360, 13'd720,  13'd720,  13'd0},
    '{13'd1, 13'd7, 13'd42, 13'd210, 13'd840, 13'd2520, 13'd5040, 13'd5040}
  };

  // Microcode program, one control word per step.
  localparam pde_ctl_t UCODE [UCODE_DEPTH] = '{
    // IDLE: take requests; an evaluate request starts the program
    '{init: 1'b1, rd_coef: 1'b0, mul1: 1'b0, mul2: 1'b0, acc: 1'b0, out_load: 1'b0,
      cond: COND_WAIT_IN, target: STEP_IDLE},
    // READ: fetch coefficient; skip to DONE when the order exceeds the degree
    '{init: 1'b0, rd_coef: 1'b1, mul1: 1'b0, mul2: 1'b0, acc: 1'b0, out_load: 1'b0,
      cond: COND_EMPTY, target: STEP_DONE},
    // MUL1: |c| * tau^k, advance tau power
    '{init: 1'b0, rd_coef: 1'b0, mul1: 1'b1, mul2: 1'b0, acc: 1'b0, out_load: 1'b0,
      cond: COND_NEXT, target: STEP_IDLE},
    // MUL2: round, times falling factorial
    '{init: 1'b0, rd_coef: 1'b0, mul1: 1'b0, mul2: 1'b1, acc: 1'b0, out_load: 1'b0,
      cond: COND_NEXT, target: STEP_IDLE},
    // ACC: add signed term, loop while terms remain
    '{init: 1'b0, rd_coef: 1'b0, mul1: 1'b0, mul2: 1'b0, acc: 1'b1, out_load: 1'b0,
      cond: COND_MORE, target: STEP_READ},
    // DONE: load output register once it is free
    '{init: 1'b0, rd_coef: 1'b0, mul1: 1'b0, mul2: 1'b0, acc: 1'b0, out_load: 1'b1,
      cond: COND_WAIT_OUT, target: STEP_IDLE},
    // unused
    '{init: 1'b0, rd_coef: 1'b0, mul1: 1'b0, mul2: 1'b0, acc: 1'b0, out_load: 1'b0,
      cond: COND_JUMP, target: STEP_IDLE},
    '{init: 1'b0, rd_coef: 1'b0, mul1: 1'b0, mul2: 1'b0, acc: 1'b0, out_load: 1'b0,
      cond: COND_JUMP, target: STEP_IDLE}
  };

endpackage

// File: hdl/pde_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
module pde_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pde_pkg::pde_stat_t  stat_i,
  output pde_pkg::pde_ctl_t   ctl_o
);
  import pde_pkg::*;

  logic [2:0] pc_q, pc_d;
  pde_ctl_t   ctl;

  assign ctl   = UCODE[pc_q];
  assign ctl_o = ctl;

  always_comb begin
    pc_d = pc_q;
    case (ctl.cond)
      COND_NEXT:     pc_d = pc_q + 3'd1;
      COND_JUMP:     pc_d = ctl.target;
      COND_WAIT_IN:  pc_d = stat_i.start ? pc_q + 3'd1 : pc_q;
      COND_EMPTY:    pc_d = stat_i.empty ? ctl.target : pc_q + 3'd1;
      COND_MORE:     pc_d = stat_i.more ? ctl.target : pc_q + 3'd1;
      COND_WAIT_OUT: pc_d = stat_i.out_busy ? pc_q : ctl.target;
      default:       pc_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_start_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.start |=> pc_q == STEP_READ)
    else $error("evaluate start did not enter READ");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= STEP_DONE)
    else $error("step counter outside program");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_DONE && stat_i.out_busy) |=> pc_q == STEP_DONE)
    else $error("DONE left while output register busy");

endmodule

// File: hdl/pde_dpath.sv
// Datapath: coefficient table, tau power, two multipliers and accumulator.
module pde_dpath #(
  parameter int MAX_DEGREE = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pde_pkg::pde_ctl_t            ctl_i,
  input  logic                         accept_i,
  input  logic                         op_i,
  input  logic [2:0]                   coeff_index_i,
  input  logic signed [31:0]           coeff_value_i,
  input  logic [2:0]                   deriv_order_i,
  input  logic [15:0]                  tau_i,
  input  logic [2:0]                   degree_i,
  output logic                         empty_o,
  output logic                         more_o,
  output logic signed [pde_pkg::ACC_W-1:0] acc_o
);
  import pde_pkg::*;

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(DEPTH);

  logic [31:0] coef_q [DEPTH];

  logic [2:0]  r_q, deg_q, n_q, slot;
  logic [15:0] t_q, p_q;
  logic        neg_q;
  logic [31:0] mag_q, coef_rd;
  logic [47:0] prod1_q, rnd1;
  logic [44:0] prod2_q;
  logic [31:0] pt, m;
  logic signed [ACC_W-1:0] acc_q, term;
  logic [2:0]  deg_lim;

  assign deg_lim = (32'(degree_i) > MAX_DEGREE) ? 3'(MAX_DEGREE) : degree_i;
  assign slot    = deg_q - n_q;
  assign coef_rd = coef_q[IDX_W'(slot)];
  assign pt      = 32'(p_q) * 32'(t_q) + 32'd16384;
  assign rnd1    = prod1_q + 48'd16384;
  assign m       = rnd1[46:15];
  assign term    = neg_q ? -$signed(ACC_W'(prod2_q)) : $signed(ACC_W'(prod2_q));

  assign empty_o = r_q > deg_q;
  assign more_o  = n_q != deg_q;
  assign acc_o   = acc_q;

  // coefficient table, undefined until written
  always_ff @(posedge clk_i) begin
    if (accept_i && (op_i == OP_LOAD) && (32'(coeff_index_i) <= MAX_DEGREE)) begin
      coef_q[IDX_W'(coeff_index_i)] <= coeff_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_coef) begin
      neg_q <= coef_rd[31];
      mag_q <= coef_rd[31] ? (32'd0 - coef_rd) : coef_rd;
    end
    if (ctl_i.mul1) begin
      prod1_q <= 48'(mag_q) * 48'(p_q);
    end
    if (ctl_i.mul2) begin
      prod2_q <= 45'(m) * 45'(FALL_TBL[n_q][r_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      deg_q <= '0;
      n_q   <= '0;
      t_q   <= '0;
      p_q   <= TAU_ONE;
      acc_q <= '0;
    end else if (ctl_i.init) begin
      if (accept_i && (op_i == OP_EVAL)) begin
        r_q   <= deriv_order_i;
        n_q   <= deriv_order_i;
        deg_q <= deg_lim;
        t_q   <= (tau_i > TAU_ONE) ? TAU_ONE : tau_i;
        p_q   <= TAU_ONE;
        acc_q <= '0;
      end
    end else begin
      if (ctl_i.mul1) begin
        p_q <= pt[30:15];
      end
      if (ctl_i.acc) begin
        acc_q <= acc_q + term;
        if (more_o) begin
          n_q <= n_q + 3'd1;
        end
      end
    end
  end

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q[ACC_W-1:45] == '0) || (acc_q[ACC_W-1:45] == '1))
    else $error("accumulator beyond term bound");

endmodule

// File: hdl/poly_derivative_eval.sv
// Top level of the polynomial derivative evaluator: ports, degree register, output register.
//
// Evaluates the r-th derivative of a polynomial of up to degree 7 held as
// signed Q16.16 coefficients, highest power first (slot i multiplies
// tau^(degree-i)). A load request (op 0) writes one slot and produces no
// result; loads to a slot above MAX_DEGREE are dropped. An evaluate request
// (op 1) produces one result: value in signed Q32.16, saturated to 48 bits
// with overflow set when clamped. tau is unsigned Q1.15 and is clamped to
// 1.0. An evaluate request runs the microcode loop READ, MUL1, MUL2, ACC
// once per contributing term (degree - r + 1 terms, or none when r exceeds
// the degree, in which case READ skips to DONE), then DONE loads the result
// register; DONE stretches while an earlier result still waits to be taken,
// and the block returns to IDLE before the next request is taken. The loop
// runs one magnitude-times-power multiplier and one times-factorial
// multiplier. A new request is accepted as soon as the previous result sits
// in the output register, even if that result has not yet been taken. The
// degree register resets to 7 and must be written only while the block is
// idle. Reading a slot that was never loaded gives an undefined result.
module poly_derivative_eval #(
  parameter int MAX_DEGREE = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [2:0]         coeff_index_i,
  input  logic signed [31:0] coeff_value_i,
  input  logic [2:0]         deriv_order_i,
  input  logic [15:0]        tau_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] value_o,
  output logic               overflow_o
);
  import pde_pkg::*;

  pde_ctl_t  ctl;
  pde_stat_t stat;

  logic [2:0]  degree_q;
  logic        accept;
  logic        empty, more;
  logic signed [ACC_W-1:0] acc;

  // output register
  logic               out_valid_q;
  logic signed [47:0] value_q;
  logic               overflow_q;
  logic               out_load_en;
  logic signed [47:0] sat_value;
  logic               sat_flag;

  // Requests are taken only in the IDLE step.
  assign in_ready_o = ctl.init;
  assign accept     = in_valid_i && in_ready_o;

  assign stat.start    = accept && (op_i == OP_EVAL);
  assign stat.empty    = empty;
  assign stat.more     = more;
  assign stat.out_busy = out_valid_q && !out_ready_i;

  pde_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  pde_dpath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .accept_i      (accept),
    .op_i          (op_i),
    .coeff_index_i (coeff_index_i),
    .coeff_value_i (coeff_value_i),
    .deriv_order_i (deriv_order_i),
    .tau_i         (tau_i),
    .degree_i      (degree_q),
    .empty_o       (empty),
    .more_o        (more),
    .acc_o         (acc)
  );

  // Degree register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 3'd7;
    end else if (cfg_we_i) begin
      degree_q <= cfg_wdata_i;
    end
  end

  // Saturate the accumulator to Q32.16.
  always_comb begin
    sat_flag  = 1'b0;
    sat_value = acc[47:0];
    if (acc > OUT_MAX) begin
      sat_flag  = 1'b1;
      sat_value = OUT_MAX[47:0];
    end else if (acc < OUT_MIN) begin
      sat_flag  = 1'b1;
      sat_value = OUT_MIN[47:0];
    end
  end

  // DONE loads the result once the previous one has left.
  assign out_load_en = ctl.out_load && !stat.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_en) begin
      value_q    <= sat_value;
      overflow_q <= sat_flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign overflow_o  = overflow_q;

  a_ovf_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (value_o == OUT_MAX[47:0] || value_o == OUT_MIN[47:0]))
    else $error("overflow flagged with unsaturated value");

  a_no_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !out_load_en)
    else $error("result loaded while taking a request");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for poly_derivative_eval: directed table, then random requests.
`timescale 1ns / 1ps

module testbench;
  import pde_pkg::*;

  localparam int MAX_DEGREE = 7;

  // Fixed-point limits used by the derivative predictor
  localparam longint unsigned TAU_ONE = 64'd32768;
  localparam longint ACC_CAP = 64'sd1 <<< 61;
  localparam longint SAT_HI  = (64'sd1 <<< 47) - 64'sd1;
  localparam longint SAT_LO  = -(64'sd1 <<< 47);

  // Settling wait after the results drain, before touching degree.
  localparam int DRAIN_CYCLES = 40;

  localparam int ITEMS_PER_PHASE = 210;
  localparam int NUM_PHASES      = 8;
  localparam logic [2:0] PHASE_DEG [NUM_PHASES] = '{3'd3, 3'd0, 3'd7, 3'd5,
                                                    3'd1, 3'd6, 3'd2, 3'd7};

  // Back-pressure: one long receiver hold-off, one sender pause until drained.
  localparam int LONG_HOLD_AT     = 250;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int PAUSE_PHASE      = 2;
  localparam int PAUSE_ITEM       = 100;

  typedef struct packed {
    logic signed [47:0] value;
    logic               overflow;
  } deriv_result_t;

  // Directed table. A ROW_DEGREE row writes the degree register once the block is idle.
  typedef enum logic {ROW_REQ, ROW_DEGREE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               op;
    logic [2:0]         idx;     // slot for a load, new degree for a ROW_DEGREE row
    logic [31:0]        coef;
    logic [2:0]         order;
    logic [15:0]        tau;
    logic               typed;   // expected value given in the row
    logic signed [47:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  // Every slot is loaded with 1.0 first, so no evaluate reads an unwritten slot.
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    //  kind        op       idx   coef           ord   tau        typed want
    '{ROW_REQ,    OP_LOAD, 3'd0, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd1, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd2, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd3, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd4, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd5, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd6, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd7, 32'h0001_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    // tau = 0: only the constant term survives
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd0, 16'd0,     1'b1, 48'sd65536},
    // tau = 1.0: sum of all eight coefficients
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd0, 16'h8000,  1'b1, 48'sd524288},
    // 7th derivative: 7! times the leading coefficient
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd7, 16'd0,     1'b1, 48'sd330301440},
    // tau above one is clamped to 1.0
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd7, 16'hFFFF,  1'b1, 48'sd330301440},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd1, 16'h4000,  1'b0, 48'sd0},
    // most negative coefficient in the leading slot
    '{ROW_REQ,    OP_LOAD, 3'd0, 32'h8000_0000, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd7, 16'd12345, 1'b1,
      -48'sd10823317585920},
    // most positive coefficient in the two leading slots
    '{ROW_REQ,    OP_LOAD, 3'd0, 32'h7FFF_FFFF, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd1, 32'h7FFF_FFFF, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd6, 16'h8000,  1'b1, 48'sd12369505806720},
    '{ROW_REQ,    OP_LOAD, 3'd5, 32'hFFFF_FFFF, 3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd0, 16'd1,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd3, 16'h4000,  1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd2, 16'h7FFF,  1'b0, 48'sd0},
    '{ROW_REQ,    OP_LOAD, 3'd7, 32'h0,         3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd0, 16'd0,     1'b1, 48'sd0},
    // degree 0: any order above it gives zero
    '{ROW_DEGREE, OP_LOAD, 3'd0, 32'h0,         3'd0, 16'd0,     1'b0, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd3, 16'd100,   1'b1, 48'sd0},
    '{ROW_REQ,    OP_EVAL, 3'd0, 32'h0,         3'd0, 16'h8000,  1'b1, 48'sd2147483647},
    '{ROW_DEGREE, OP_LOAD, 3'd7, 32'h0,         3'd0, 16'd0,     1'b0, 48'sd0}
  };

  logic               clk_i;
  logic               rst_ni     = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [2:0]         cfg_wdata  = 3'd0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               req_op     = OP_LOAD;
  logic [2:0]         req_idx    = 3'd0;
  logic signed [31:0] req_coef   = 32'sd0;
  logic [2:0]         req_order  = 3'd0;
  logic [15:0]        req_tau    = 16'd0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [47:0] res_value;
  logic               res_ovf;

  // Predictor state: coefficient slots and the degree register
  logic signed [31:0] coef_mem [MAX_DEGREE+1];
  logic [2:0]         deg_reg = 3'd7;

  deriv_result_t pending_results [$];
  int            err_cnt      = 0;
  int            items_sent   = 0;
  int            results_seen = 0;

  poly_derivative_eval #(
    .MAX_DEGREE(MAX_DEGREE)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (req_op),
    .coeff_index_i (req_idx),
    .coeff_value_i (req_coef),
    .deriv_order_i (req_order),
    .tau_i         (req_tau),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .value_o       (res_value),
    .overflow_o    (res_ovf)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // r-th derivative of the held polynomial at tau, in Q32.16 with saturation
  function automatic deriv_result_t predict_derivative(input logic [2:0] order,
                                                       input logic [15:0] tau_in);
    deriv_result_t    res;
    longint unsigned  t, p, mag, m, ff;
    longint           c, term, sum;
    int               deg, n, i, j;
    t   = (tau_in > TAU_ONE) ? TAU_ONE : tau_in;
    deg = (deg_reg > MAX_DEGREE) ? MAX_DEGREE : deg_reg;
    sum = 0;
    for (i = 0; i <= deg; i++) begin
      n = deg - i;
      if (n < order) continue;
      c   = coef_mem[i];
      mag = (c < 0) ? -c : c;
      // tau^(n-r) in Q1.15, each step rounded half up
      p = TAU_ONE;
      for (j = 0; j < n - order; j++) p = (p * t + 64'd16384) >> 15;
      m  = (mag * p + 64'd16384) >> 15;
      ff = 1;
      for (j = 0; j < order; j++) ff = ff * longint'(n - j);
      if (ff != 0 && m > longint'(ACC_CAP) / ff) term = ACC_CAP;
      else term = m * ff;
      if (c < 0) term = -term;
      sum = sum + term;
      if (sum > ACC_CAP) sum = ACC_CAP;
      if (sum < -ACC_CAP) sum = -ACC_CAP;
    end
    res.overflow = 1'b0;
    if (sum > SAT_HI) begin
      sum = SAT_HI;
      res.overflow = 1'b1;
    end else if (sum < SAT_LO) begin
      sum = SAT_LO;
      res.overflow = 1'b1;
    end
    res.value = sum[47:0];
    return res;
  endfunction

  // Idle stretch before the next request; some runs of requests go back to back.
  function automatic int sender_gap();
    if ((items_sent / 50) % 4 == 1) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Present one request, hold it until accepted, then update the predictor.
  task automatic issue_request(input logic op, input logic [2:0] idx, input logic [31:0] coef,
                               input logic [2:0] order, input logic [15:0] tau,
                               input logic typed, input logic signed [47:0] want);
    int            gap;
    deriv_result_t exp_res;
    in_valid  <= 1'b1;
    req_op    <= op;
    req_idx   <= idx;
    req_coef  <= coef;
    req_order <= order;
    req_tau   <= tau;
    do @(posedge clk_i); while (!in_ready);
    if (op == OP_LOAD) begin
      coef_mem[idx] = coef;
    end else begin
      if (typed) begin
        exp_res.value    = want;
        exp_res.overflow = 1'b0;
      end else begin
        exp_res = predict_derivative(order, tau);
      end
      pending_results = {pending_results, exp_res};
    end
    items_sent++;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every outstanding result, then let any trailing load settle.
  task automatic wait_results_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_degree(input logic [2:0] d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk_i);
    deg_reg = d;
    cfg_we  <= 1'b0;
  endtask

  // One random request. Coefficients and tau lean toward their extremes.
  task automatic random_request();
    logic        op;
    logic [2:0]  idx, order;
    logic [31:0] coef;
    logic [15:0] tau;
    op  = ($urandom_range(0, 9) < 4) ? OP_LOAD : OP_EVAL;
    idx = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0:       coef = 32'h8000_0000;
      1:       coef = 32'h7FFF_FFFF;
      2:       coef = $urandom_range(0, 1 << 20);
      3:       coef = -$urandom_range(0, 1 << 20);
      default: coef = $urandom();
    endcase
    // at least half the orders stay within the degree so terms actually contribute
    if ($urandom_range(0, 1) == 0) order = 3'($urandom_range(0, deg_reg));
    else order = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0:       tau = 16'd0;
      1:       tau = 16'h8000;
      2:       tau = 16'($urandom_range(32769, 65535));  // clamped to 1.0
      3:       tau = 16'h7FFF;
      default: tau = 16'($urandom_range(0, 32768));
    endcase
    issue_request(op, idx, coef, order, tau, 1'b0, 48'sd0);
  endtask

  // Result side: random stalls, one long hold-off, check against the oldest expectation.
  initial begin
    int            stall;
    deriv_result_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (results_seen == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      else if ((results_seen / 64) % 3 == 0) stall = 0;
      else stall = $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("value: unexpected result %0d with no evaluate pending", res_value);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (res_value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, res_value);
          err_cnt++;
        end
        if (res_ovf !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, res_ovf);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases at several degrees.
  initial begin
    int row, ph, k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < DIR_ROWS; row++) begin
      if (DIR_TBL[row].kind == ROW_DEGREE) begin
        wait_results_drained();
        write_degree(DIR_TBL[row].idx);
      end else begin
        issue_request(DIR_TBL[row].op, DIR_TBL[row].idx, DIR_TBL[row].coef,
                      DIR_TBL[row].order, DIR_TBL[row].tau, DIR_TBL[row].typed,
                      DIR_TBL[row].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results_drained();
      write_degree(PHASE_DEG[ph]);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender stops once mid-phase until the block has emptied
        if (ph == PAUSE_PHASE && k == PAUSE_ITEM) wait_results_drained();
        random_request();
      end
    end

    wait_results_drained();
    if (err_cnt == 0) begin
      $display("poly_derivative_eval regression: pass");
    end else begin
      $display("poly_derivative_eval regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #6_000_000;
    $display("poly_derivative_eval regression: fail");
    $finish;
  end

endmodule
